// ===== hdl/exl_pkg.sv =====
// Package for the expression language lexer: token kinds, character classes,
// the token record and the counter widths. No dependencies.
package exl_pkg;

  // Counter widths; the reported fields are clipped to 16 bits.
  localparam int LINE_WIDTH   = 16;
  localparam int COLUMN_WIDTH = 16;
  localparam int LENGTH_WIDTH = 16;

  // Token queue geometry.
  localparam int TQ_DEPTH = 4;
  localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
  localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

  // Token kinds.
  localparam logic [4:0] K_NUM     = 5'd0;
  localparam logic [4:0] K_ID      = 5'd1;
  localparam logic [4:0] K_PRINT   = 5'd2;
  localparam logic [4:0] K_IF      = 5'd3;
  localparam logic [4:0] K_WHILE   = 5'd4;
  localparam logic [4:0] K_ASSIGN  = 5'd5;
  localparam logic [4:0] K_EQ      = 5'd6;
  localparam logic [4:0] K_NOT     = 5'd7;
  localparam logic [4:0] K_NE      = 5'd8;
  localparam logic [4:0] K_BAND    = 5'd9;
  localparam logic [4:0] K_LAND    = 5'd10;
  localparam logic [4:0] K_BOR     = 5'd11;
  localparam logic [4:0] K_LOR     = 5'd12;
  localparam logic [4:0] K_BNOT    = 5'd13;
  localparam logic [4:0] K_XOR     = 5'd14;
  localparam logic [4:0] K_ADD     = 5'd15;
  localparam logic [4:0] K_SUB     = 5'd16;
  localparam logic [4:0] K_MUL     = 5'd17;
  localparam logic [4:0] K_DIV     = 5'd18;
  localparam logic [4:0] K_LT      = 5'd19;
  localparam logic [4:0] K_LE      = 5'd20;
  localparam logic [4:0] K_GT      = 5'd21;
  localparam logic [4:0] K_GE      = 5'd22;
  localparam logic [4:0] K_SEMI    = 5'd23;
  localparam logic [4:0] K_LPAR    = 5'd24;
  localparam logic [4:0] K_RPAR    = 5'd25;
  localparam logic [4:0] K_LBRACE  = 5'd26;
  localparam logic [4:0] K_RBRACE  = 5'd27;
  localparam logic [4:0] K_EOF     = 5'd28;
  localparam logic [4:0] K_INVALID = 5'd29;
  localparam logic [4:0] K_NONE    = 5'd31;

  // Keyword patterns in the identifier window, newest byte lowest.
  localparam logic [39:0] KW_PRINT = 40'h7072696E74;
  localparam logic [39:0] KW_WHILE = 40'h7768696C65;
  localparam logic [15:0] KW_IF    = 16'h6966;

  // Characters with special meaning.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // Token in progress: a number, an identifier or a prefix operator.
  typedef enum logic [3:0] {
    PK_IDLE, PK_NUM, PK_ID,
    PK_OP_EQ, PK_OP_BANG, PK_OP_AMP, PK_OP_BAR, PK_OP_LT, PK_OP_GT
  } pend_t;

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_USCORE);
  endfunction

  function automatic logic is_newline(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || is_newline(c);
  endfunction

  // Kind of a one-character token that never takes a second character.
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "~":     k = K_BNOT;
      "^":     k = K_XOR;
      "+":     k = K_ADD;
      "-":     k = K_SUB;
      "*":     k = K_MUL;
      "/":     k = K_DIV;
      ";":     k = K_SEMI;
      "(":     k = K_LPAR;
      ")":     k = K_RPAR;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Prefix operator started by a character, PK_IDLE if none.
  function automatic pend_t op_start(input logic [7:0] c);
    pend_t p;
    case (c)
      "=":     p = PK_OP_EQ;
      "!":     p = PK_OP_BANG;
      "&":     p = PK_OP_AMP;
      "|":     p = PK_OP_BAR;
      "<":     p = PK_OP_LT;
      ">":     p = PK_OP_GT;
      default: p = PK_IDLE;
    endcase
    return p;
  endfunction

  // Second character that completes a prefix operator.
  function automatic logic [7:0] op_second(input pend_t p);
    logic [7:0] c;
    case (p)
      PK_OP_AMP: c = "&";
      PK_OP_BAR: c = "|";
      default:   c = "=";
    endcase
    return c;
  endfunction

  function automatic logic is_op(input pend_t p);
    return (p != PK_IDLE) && (p != PK_NUM) && (p != PK_ID);
  endfunction

  function automatic logic [4:0] op_single(input pend_t p);
    logic [4:0] k;
    case (p)
      PK_OP_EQ:   k = K_ASSIGN;
      PK_OP_BANG: k = K_NOT;
      PK_OP_AMP:  k = K_BAND;
      PK_OP_BAR:  k = K_BOR;
      PK_OP_LT:   k = K_LT;
      PK_OP_GT:   k = K_GT;
      default:    k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] op_double(input pend_t p);
    logic [4:0] k;
    case (p)
      PK_OP_EQ:   k = K_EQ;
      PK_OP_BANG: k = K_NE;
      PK_OP_AMP:  k = K_LAND;
      PK_OP_BAR:  k = K_LOR;
      PK_OP_LT:   k = K_LE;
      PK_OP_GT:   k = K_GE;
      default:    k = K_NONE;
    endcase
    return k;
  endfunction

  // Clip a counter value to the 16-bit field.
  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== hdl/exl_core.sv =====
// Lexer core: input register, lexer state and the single-pass step logic
// that turns one registered byte into up to two tokens. Uses exl_pkg.
module exl_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_char_code,
  input  logic                     in_end_of_text,
  input  logic                     q_room,
  output logic [1:0]               push_n,
  output exl_pkg::tok_t            tok_a,
  output exl_pkg::tok_t            tok_b
);
  import exl_pkg::*;

  logic                    stg_valid_r;
  logic [7:0]              stg_char_r;
  logic                    stg_eot_r;
  logic                    step_fire;

  pend_t                   pend_r, pend_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt, line_adv;
  logic [COLUMN_WIDTH-1:0] col_r, col_nxt, col_adv;
  logic [LINE_WIDTH-1:0]   tsl_r, tsl_nxt;
  logic [COLUMN_WIDTH-1:0] tsc_r, tsc_nxt;
  logic [LENGTH_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [39:0]             win_r, win_nxt;
  logic                    halt_r, halt_nxt;

  tok_t                    flush_tok, eof_tok, fresh_tok;
  logic                    flush_valid, fresh_valid;
  logic [4:0]              id_kind, sk;
  pend_t                   ops;
  logic [7:0]              c;

  // Input register: refills when empty or when the held item moves on this cycle.
  assign step_fire = stg_valid_r && q_room;
  assign in_ready  = !stg_valid_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      stg_char_r <= in_char_code;
      stg_eot_r  <= in_end_of_text;
    end
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PK_IDLE;
      line_r <= LINE_WIDTH'(1);
      col_r  <= '0;
      tsl_r  <= LINE_WIDTH'(1);
      tsc_r  <= '0;
      cnt_r  <= '0;
      win_r  <= '0;
      halt_r <= 1'b0;
    end else if (step_fire) begin
      pend_r <= pend_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      cnt_r  <= cnt_nxt;
      win_r  <= win_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Saturating position and length updates for this byte.
  assign c        = stg_char_r;
  assign line_adv = (is_newline(c) && (line_r != '1)) ? line_r + 1'b1 : line_r;
  assign col_adv  = is_newline(c) ? '0 : ((col_r != '1) ? col_r + 1'b1 : col_r);
  assign cnt_inc  = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;

  // Token formed by the pending state when it is cut off.
  always_comb begin
    if ((cnt_r == LENGTH_WIDTH'(5)) && (win_r == KW_PRINT)) begin
      id_kind = K_PRINT;
    end else if ((cnt_r == LENGTH_WIDTH'(2)) && (win_r[15:0] == KW_IF)) begin
      id_kind = K_IF;
    end else if ((cnt_r == LENGTH_WIDTH'(5)) && (win_r == KW_WHILE)) begin
      id_kind = K_WHILE;
    end else begin
      id_kind = K_ID;
    end
    flush_valid    = (pend_r != PK_IDLE);
    flush_tok.line = clip16(32'(tsl_r));
    flush_tok.col  = clip16(32'(tsc_r));
    flush_tok.last = 1'b0;
    if (pend_r == PK_NUM) begin
      flush_tok.kind = K_NUM;
      flush_tok.len  = clip16(32'(cnt_r));
    end else if (pend_r == PK_ID) begin
      flush_tok.kind = id_kind;
      flush_tok.len  = clip16(32'(cnt_r));
    end else begin
      flush_tok.kind = op_single(pend_r);
      flush_tok.len  = 16'd1;
    end
    eof_tok.kind = K_EOF;
    eof_tok.line = clip16(32'(line_r));
    eof_tok.col  = (col_r != '0) ? clip16(32'(col_r)) : 16'd1;
    eof_tok.len  = '0;
    eof_tok.last = 1'b0;
  end

  // Step: next state and the tokens caused by the registered item.
  always_comb begin
    pend_nxt  = pend_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tsl_nxt   = tsl_r;
    tsc_nxt   = tsc_r;
    cnt_nxt   = cnt_r;
    win_nxt   = win_r;
    halt_nxt  = halt_r;
    tok_a     = '0;
    tok_b     = '0;
    push_n    = 2'd0;
    sk        = single_kind(c);
    ops       = op_start(c);
    fresh_tok = '0;
    fresh_valid = 1'b0;

    if (stg_eot_r) begin
      // End of text flushes, reports eof and returns to the reset state.
      if (flush_valid) begin
        tok_a  = flush_tok;
        tok_b  = eof_tok;
        push_n = 2'd2;
      end else begin
        tok_a  = eof_tok;
        push_n = 2'd1;
      end
      pend_nxt = PK_IDLE;
      line_nxt = LINE_WIDTH'(1);
      col_nxt  = '0;
      tsl_nxt  = LINE_WIDTH'(1);
      tsc_nxt  = '0;
      cnt_nxt  = '0;
      win_nxt  = '0;
      halt_nxt = 1'b0;
    end else if (!halt_r) begin
      line_nxt = line_adv;
      col_nxt  = col_adv;
      if ((pend_r == PK_NUM) && is_digit(c)) begin
        cnt_nxt = cnt_inc;
      end else if ((pend_r == PK_ID) && (is_ident_start(c) || is_digit(c))) begin
        cnt_nxt = cnt_inc;
        win_nxt = {win_r[31:0], c};
      end else if (is_op(pend_r) && (c == op_second(pend_r))) begin
        tok_a      = flush_tok;
        tok_a.kind = op_double(pend_r);
        tok_a.len  = 16'd2;
        push_n     = 2'd1;
        pend_nxt   = PK_IDLE;
      end else begin
        // The pending token ends here; the byte is lexed afresh.
        pend_nxt = PK_IDLE;
        fresh_tok.line = clip16(32'(line_adv));
        fresh_tok.col  = clip16(32'(col_adv));
        if (is_space(c)) begin
          fresh_valid = 1'b0;
        end else if (is_digit(c)) begin
          pend_nxt = PK_NUM;
          tsl_nxt  = line_adv;
          tsc_nxt  = col_adv;
          cnt_nxt  = LENGTH_WIDTH'(1);
        end else if (is_ident_start(c)) begin
          pend_nxt = PK_ID;
          tsl_nxt  = line_adv;
          tsc_nxt  = col_adv;
          cnt_nxt  = LENGTH_WIDTH'(1);
          win_nxt  = {32'd0, c};
        end else if (sk != K_NONE) begin
          fresh_valid    = 1'b1;
          fresh_tok.kind = sk;
          fresh_tok.len  = 16'd1;
        end else if (ops != PK_IDLE) begin
          pend_nxt = ops;
          tsl_nxt  = line_adv;
          tsc_nxt  = col_adv;
          cnt_nxt  = LENGTH_WIDTH'(1);
        end else begin
          fresh_valid    = 1'b1;
          fresh_tok.kind = K_INVALID;
          fresh_tok.len  = '0;
          halt_nxt       = 1'b1;
        end
        if (flush_valid) begin
          tok_a = flush_tok;
          if (fresh_valid) begin
            tok_b  = fresh_tok;
            push_n = 2'd2;
          end else begin
            push_n = 2'd1;
          end
        end else if (fresh_valid) begin
          tok_a  = fresh_tok;
          push_n = 2'd1;
        end
      end
    end

    // Mark the final token of this item.
    if (push_n == 2'd1) begin
      tok_a.last = 1'b1;
    end else if (push_n == 2'd2) begin
      tok_b.last = 1'b1;
    end
    if (!step_fire) begin
      push_n = 2'd0;
    end
  end

  // A halted lexer never holds a token in progress.
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (pend_r == PK_IDLE))
    else $error("halted with a pending token");

  // Bytes seen while halted produce nothing.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && halt_r && !stg_eot_r) |-> (push_n == 2'd0))
    else $error("token produced while halted");

  // End of text rearms the lexer at line 1.
  a_eot_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && stg_eot_r) |=> (!halt_r && (pend_r == PK_IDLE) &&
                                  (line_r == LINE_WIDTH'(1)) && (col_r == '0)))
    else $error("end of text did not rearm the lexer");

  // End of text always ends with an eof token.
  a_eot_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && stg_eot_r && (push_n == 2'd1)) |-> (tok_a.kind == K_EOF))
    else $error("end of text without eof");

endmodule

// ===== hdl/exl_tokq.sv =====
// Token queue: takes up to two tokens per cycle from the lexer core, hands
// one per cycle to the result channel while out_ready is high. Uses exl_pkg.
module exl_tokq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_n,
  input  exl_pkg::tok_t   tok_a,
  input  exl_pkg::tok_t   tok_b,
  output logic            q_room,
  output logic            out_valid,
  input  logic            out_ready,
  output exl_pkg::tok_t   out_tok
);
  import exl_pkg::*;

  tok_t                ent_r [TQ_DEPTH];
  logic [TQ_PTR_W-1:0] wr_r, wr_nxt;
  logic [TQ_PTR_W-1:0] rd_r, rd_nxt;
  logic [TQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                pop;
  logic [TQ_PTR_W-1:0] wr_b;

  // Room for a two-token item is required before the core moves on.
  assign q_room    = (cnt_r <= TQ_CNT_W'(TQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_tok   = ent_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_b      = wr_r + 1'b1;

  // Pointer and fill count updates.
  always_comb begin
    wr_nxt  = wr_r + TQ_PTR_W'(push_n);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + TQ_CNT_W'(push_n) - TQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      ent_r[wr_r] <= tok_a;
    end
    if (push_n == 2'd2) begin
      ent_r[wr_b] <= tok_b;
    end
  end

  // The fill count never passes the depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= TQ_CNT_W'(TQ_DEPTH))
    else $error("token queue overflow");

  // Pushes arrive only when the queue announced room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> q_room)
    else $error("push without room");

endmodule

// ===== hdl/expression_language_lexer.sv =====
// Top level of the expression language lexer: input register and lexer core
// feeding a four-entry token queue. Uses exl_pkg, exl_core and exl_tokq.

// The lexer takes one source byte per cycle and delivers one token per cycle
// while out_ready is high. A byte is held in an input register while the step
// logic classifies it against the pending token; the resulting tokens (none,
// one or two) land in a four-entry queue that drives the out_ ports. The core
// moves an item on only while the queue has two free entries: with one token
// or fewer per byte the rate is one byte per cycle, and a run of bytes that
// each end one token and start another is limited by the single result port
// to one token per cycle. An invalid byte yields an INVALID token and the
// following bytes are dropped until end_of_text, which flushes, reports EOF
// and rearms the lexer. There is no clearing pass after reset.
module expression_language_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);
  import exl_pkg::*;

  logic       q_room;
  logic [1:0] push_n;
  tok_t       tok_a, tok_b, out_tok;

  exl_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .q_room         (q_room),
    .push_n         (push_n),
    .tok_a          (tok_a),
    .tok_b          (tok_b)
  );

  exl_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .tok_a     (tok_a),
    .tok_b     (tok_b),
    .q_room    (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  // Result fields for each transfer.
  assign out_token_kind   = out_tok.kind;
  assign out_start_line   = out_tok.line;
  assign out_start_column = out_tok.col;
  assign out_token_length = out_tok.len;
  assign out_last_of_run  = out_tok.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for expression_language_lexer: directed token, line
// and invalid-byte cases, then random program text with idling.
// Depends on exl_pkg and the lexer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import exl_pkg::*;

  localparam longint unsigned LINE_MAX = (64'd1 << LINE_WIDTH) - 1;
  localparam longint unsigned COL_MAX  = (64'd1 << COLUMN_WIDTH) - 1;
  localparam longint unsigned LEN_MAX  = (64'd1 << LENGTH_WIDTH) - 1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_token_kind;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  expression_language_lexer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  // Lexer state as predicted by the testbench.
  pend_t           pend_state;
  longint unsigned line_cnt, col_cnt, tok_line, tok_col, tok_len;
  logic [39:0]     word_window;
  logic            halted;

  // Tokens still owed by the block, oldest first, and those of the current byte.
  tok_t tokens_due[$];
  tok_t item_tokens[$];

  // Run statistics and idling controls.
  int fails = 0;
  int items_sent = 0;
  int lexed_items = 0;
  int eot_sent = 0;
  int invalid_seen = 0;
  int tokens_checked = 0;
  int burst_left = 0;
  bit gaps_on = 1;
  bit rx_stalls = 1;

  // Vocabulary for random program text.
  string op_words[23] = '{"=", "==", "!", "!=", "&", "&&", "|", "||", "~", "^", "+",
                          "-", "*", "/", "<", "<=", ">", ">=", ";", "(", ")", "{", "}"};
  string near_words[11] = '{"print", "if", "while", "prin", "printf", "i", "iff",
                            "whil", "while2", "If", "PRINT"};
  string blanks    = " \t\r\n";
  string letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #1ms;
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------

  function automatic logic [15:0] sat16(input longint unsigned v);
    return (v > 64'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_USCORE);
  endfunction

  // Operators that are complete after one character.
  function automatic logic [4:0] plain_op_kind(input logic [7:0] c);
    case (c)
      "~":     return K_BNOT;
      "^":     return K_XOR;
      "+":     return K_ADD;
      "-":     return K_SUB;
      "*":     return K_MUL;
      "/":     return K_DIV;
      ";":     return K_SEMI;
      "(":     return K_LPAR;
      ")":     return K_RPAR;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      default: return K_NONE;
    endcase
  endfunction

  // Operators that may take a second character.
  function automatic pend_t prefix_op(input logic [7:0] c);
    case (c)
      "=":     return PK_OP_EQ;
      "!":     return PK_OP_BANG;
      "&":     return PK_OP_AMP;
      "|":     return PK_OP_BAR;
      "<":     return PK_OP_LT;
      ">":     return PK_OP_GT;
      default: return PK_IDLE;
    endcase
  endfunction

  function automatic logic [7:0] second_of(input pend_t p);
    if (p == PK_OP_AMP) return "&";
    if (p == PK_OP_BAR) return "|";
    return "=";
  endfunction

  function automatic logic [4:0] short_kind(input pend_t p);
    case (p)
      PK_OP_EQ:   return K_ASSIGN;
      PK_OP_BANG: return K_NOT;
      PK_OP_AMP:  return K_BAND;
      PK_OP_BAR:  return K_BOR;
      PK_OP_LT:   return K_LT;
      default:    return K_GT;
    endcase
  endfunction

  function automatic logic [4:0] long_kind(input pend_t p);
    case (p)
      PK_OP_EQ:   return K_EQ;
      PK_OP_BANG: return K_NE;
      PK_OP_AMP:  return K_LAND;
      PK_OP_BAR:  return K_LOR;
      PK_OP_LT:   return K_LE;
      default:    return K_GE;
    endcase
  endfunction

  function automatic void clear_lexer_state();
    pend_state  = PK_IDLE;
    line_cnt    = 1;
    col_cnt     = 0;
    tok_line    = 1;
    tok_col     = 0;
    tok_len     = 0;
    word_window = '0;
    halted      = 1'b0;
  endfunction

  function automatic void add_token(input logic [4:0] kind, input longint unsigned ln,
                                    input longint unsigned col, input longint unsigned len);
    tok_t t;
    t.kind = kind;
    t.line = sat16(ln);
    t.col  = sat16(col);
    t.len  = sat16(len);
    t.last = 1'b0;
    item_tokens = {item_tokens, t};
  endfunction

  function automatic void open_token(input pend_t p);
    pend_state = p;
    tok_line   = line_cnt;
    tok_col    = col_cnt;
    tok_len    = 1;
  endfunction

  // An identifier becomes a keyword only when its whole text matches.
  function automatic logic [4:0] word_kind();
    if (tok_len == 5 && word_window == KW_PRINT) return K_PRINT;
    if (tok_len == 2 && word_window[15:0] == KW_IF) return K_IF;
    if (tok_len == 5 && word_window == KW_WHILE) return K_WHILE;
    return K_ID;
  endfunction

  // Emit whatever token is in progress.
  function automatic void end_pending();
    case (pend_state)
      PK_IDLE: ;
      PK_NUM:  add_token(K_NUM, tok_line, tok_col, tok_len);
      PK_ID:   add_token(word_kind(), tok_line, tok_col, tok_len);
      default: add_token(short_kind(pend_state), tok_line, tok_col, 1);
    endcase
    pend_state = PK_IDLE;
  endfunction

  // Mark the final token of this byte and queue the byte's tokens.
  function automatic void close_item();
    if (item_tokens.size() > 0) begin
      item_tokens[item_tokens.size() - 1].last = 1'b1;
      tokens_due = {tokens_due, item_tokens};
      item_tokens.delete();
    end
  endfunction

  // Advance the predicted lexer by one accepted input transfer.
  function automatic void lex_byte(input logic [7:0] c, input logic eot);
    logic [4:0] k;
    pend_t      p;
    if (eot) begin
      end_pending();
      add_token(K_EOF, line_cnt, (col_cnt != 0) ? col_cnt : 1, 0);
      clear_lexer_state();
      close_item();
      return;
    end
    if (halted) return;
    lexed_items++;

    // Position of this byte.
    if (c == CH_LF || c == CH_CR) begin
      if (line_cnt < LINE_MAX) line_cnt++;
      col_cnt = 0;
    end else if (col_cnt < COL_MAX) begin
      col_cnt++;
    end

    // The byte may continue the token in progress.
    if (pend_state == PK_NUM && is_num_char(c)) begin
      if (tok_len < LEN_MAX) tok_len++;
      return;
    end
    if (pend_state == PK_ID && (is_word_start(c) || is_num_char(c))) begin
      if (tok_len < LEN_MAX) tok_len++;
      word_window = {word_window[31:0], c};
      return;
    end
    if (!(pend_state inside {PK_IDLE, PK_NUM, PK_ID}) && c == second_of(pend_state)) begin
      add_token(long_kind(pend_state), tok_line, tok_col, 2);
      pend_state = PK_IDLE;
      close_item();
      return;
    end
    end_pending();

    // Otherwise the byte is lexed afresh.
    k = plain_op_kind(c);
    p = prefix_op(c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
    end else if (is_num_char(c)) begin
      open_token(PK_NUM);
    end else if (is_word_start(c)) begin
      open_token(PK_ID);
      word_window = {32'd0, c};
    end else if (k != K_NONE) begin
      add_token(k, line_cnt, col_cnt, 1);
    end else if (p != PK_IDLE) begin
      open_token(p);
    end else begin
      add_token(K_INVALID, line_cnt, col_cnt, 0);
      halted = 1'b1;
      invalid_seen++;
    end
    close_item();
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Compare every result transfer with the oldest predicted token.
  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d line %0d column %0d length %0d",
               out_token_kind, out_start_line, out_start_column, out_token_length);
        fails++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", 16'(want.kind), 16'(out_token_kind));
        check_field("start_line", want.line, out_start_line);
        check_field("start_column", want.col, out_start_column);
        check_field("token_length", want.len, out_token_length);
        check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
        tokens_checked++;
      end
    end
  end

  // Receiver: with rx_stalls, alternating ready and stall runs of random length; else always ready.
  initial begin
    int run;
    out_ready = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (!rx_stalls) begin
        out_ready <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        out_ready <= !out_ready;
        run = out_ready ? $urandom_range(0, 4) : $urandom_range(0, 10);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // One input transfer; with gaps_on the sender works in bursts separated by random gaps.
  task automatic send_item(input logic [7:0] c, input logic eot);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    lex_byte(c, eot);
    items_sent++;
    if (eot) eot_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eot();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hold the input idle until every predicted token has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
  endtask

  task automatic test_keywords_and_names();
    send_text("print\tif while _Zz9 printx if1 wh 0 42");
    send_eot();
  endtask

  // Every operator, both alone and as a prefix of a longer one.
  task automatic test_operators();
    send_text("= == ! != & && | || < <= > >= ~^+-*/;(){}=<!>");
    send_eot();
  endtask

  // CR and LF each open a line; an empty line reports end of text at column 1.
  task automatic test_line_counting();
    send_text("12\r\n345 \n\nx");
    send_eot();
    send_text("a\n");
    send_eot();
    send_eot();
  endtask

  // Invalid bytes flush the pending token, halt, and only end of text rearms.
  task automatic test_invalid_bytes();
    send_text("ab");
    send_item(8'h00, 1'b0);
    send_text("xy+");
    send_eot();
    send_text("<");
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_eot();
    send_text("7@");
    send_eot();
    wait_drained();
  endtask

  // One random program: mostly well-formed tokens, a little noise.
  task automatic random_program();
    int n_tok;
    int r;
    n_tok = $urandom_range(3, 30);
    repeat (n_tok) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        repeat ($urandom_range(1, 6)) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (r < 50) begin
        if ($urandom_range(0, 2) == 0) begin
          send_text(near_words[$urandom_range(0, 10)]);
        end else begin
          send_item(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
          repeat ($urandom_range(0, 6))
            send_item(word_tail[$urandom_range(0, word_tail.len() - 1)], 1'b0);
        end
      end else if (r < 80) begin
        send_text(op_words[$urandom_range(0, 22)]);
      end else if (r < 98) begin
        repeat ($urandom_range(1, 3)) send_item(blanks[$urandom_range(0, 3)], 1'b0);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 1) == 0) send_item(blanks[$urandom_range(0, 3)], 1'b0);
    end
    // Now and then the text runs on into the next program.
    if ($urandom_range(0, 9) != 0) send_eot();
  endtask

  task automatic test_random_text();
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < 1100) begin
      case ($urandom_range(0, 3))
        0:       begin gaps_on = 1'b0; rx_stalls = 1'b0; end
        1:       begin gaps_on = 1'b1; rx_stalls = 1'b0; end
        2:       begin gaps_on = 1'b0; rx_stalls = 1'b1; end
        default: begin gaps_on = 1'b1; rx_stalls = 1'b1; end
      endcase
      random_program();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    send_eot();
  endtask

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = 8'h00;
    in_end_of_text = 1'b0;
    clear_lexer_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_keywords_and_names();
    test_operators();
    test_line_counting();
    test_invalid_bytes();
    test_random_text();

    wait_drained();
    repeat (16) @(negedge clk);

    $display("Run covered %0d input transfers (%0d lexed bytes, %0d end of text, %0d invalid).",
             items_sent, lexed_items, eot_sent, invalid_seen);
    $display("%0d tokens were compared against the prediction, %0d mismatches.",
             tokens_checked, fails);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
